// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define FSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared widths, codes and types of the fixed-slot pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  localparam int ADDR_W     = 32;
  localparam int BYTES_W    = 24;
  localparam int TYPE_W     = 13;
  localparam int ALIGN_W    = 13;
  localparam int OFS_W      = 12;
  localparam int STRIDE_W   = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_REBUILD = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_START   = 3'd0,
    CFG_POOL_BYTES   = 3'd1,
    CFG_TYPE_BYTES   = 3'd2,
    CFG_ALIGNMENT    = 3'd3,
    CFG_ALIGN_OFFSET = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REB_SETUP,
    S_REB_DIV,
    S_REB_FILL,
    S_ALLOC_RD,
    S_ALLOC_WB,
    S_REL_CHK,
    S_REL_DIV,
    S_FINISH
  } state_t;

  // Divider result as seen by the control logic.
  typedef struct packed {
    logic                done;
    logic [ADDR_W-1:0]   quot;
    logic [STRIDE_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ----- sv/fsp_ram.sv -----
// ----------------------------------------------------------------------------
// fsp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsp_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/fsp_div.sv -----
// ----------------------------------------------------------------------------
// fsp_div
// Restoring divider, one quotient bit per cycle, quotient and remainder held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fsp_div
  import fsp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [ADDR_W-1:0]   dividend,
  input  wire logic [STRIDE_W-1:0] divisor,
  output div_res_t                 res
);

  localparam int CNT_W = $clog2(ADDR_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   quo_r, quo_nxt;
  logic [STRIDE_W-1:0] rem_r, rem_nxt;
  logic [STRIDE_W-1:0] dvs_r, dvs_nxt;
  logic [STRIDE_W:0]   trial;
  logic [STRIDE_W:0]   diff;
  logic                ge;

  // Shift the next dividend bit into the partial remainder, subtract if it fits.
  assign trial = {rem_r, quo_r[ADDR_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ADDR_W-2:0], ge};
      rem_nxt = ge ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res = {done_r, quo_r, rem_r};

  `FSP_ASSERT(a_rem_below_divisor, clk, rst_n, done_r && (dvs_r != '0) |-> rem_r < dvs_r, "remainder not below divisor")
  `FSP_ASSERT(a_done_ends_run, clk, rst_n, done_r |-> !busy_r && $past(busy_r), "done without a running division")

endmodule

`default_nettype wire

// ----- sv/fixed_slot_pool_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_top
// Fixed-slot pool allocator: LIFO free list kept in a next-slot link RAM.
//
//   channel | ports                               | transfer when
//   --------+-------------------------------------+----------------------
//   input   | in_action, in_address               | start && !busy
//   result  | out_status, out_slot_address,       | out_valid (one cycle)
//           | out_in_pool, out_used_bytes         |
//   config  | cfg_index, cfg_wdata                | cfg_we
//
// One item at a time; busy stays high from the accepting edge up to and
// including the cycle the result strobe is shown.
// No operation and empty allocate go straight to the result. Allocate:
// link RAM read, then pop. Release: precheck, then the 32-step shared
// divider. Rebuild: the divider, then one link write per slot; the divider
// is skipped when the stride is zero or the adjustment overruns the region.
// Reset clears the list to empty; the link RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fixed_slot_pool_allocator_top
  import fsp_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_action,
  input  wire logic [ADDR_W-1:0]     in_address,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [ADDR_W-1:0]          out_slot_address,
  output logic                       out_in_pool,
  output logic [BYTES_W-1:0]         out_used_bytes,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam logic [IW-1:0] NULL_IDX = IW'(SLOTS);

  // Configuration registers
  logic [ADDR_W-1:0]  pool_start_r;
  logic [BYTES_W-1:0] pool_bytes_r;
  logic [TYPE_W-1:0]  type_bytes_r;
  logic [ALIGN_W-1:0] alignment_r;
  logic [OFS_W-1:0]   align_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_start_r   <= '0;
      pool_bytes_r   <= '0;
      type_bytes_r   <= TYPE_W'(16);
      alignment_r    <= ALIGN_W'(8);
      align_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_START:   pool_start_r   <= cfg_wdata[ADDR_W-1:0];
        CFG_POOL_BYTES:   pool_bytes_r   <= cfg_wdata[BYTES_W-1:0];
        CFG_TYPE_BYTES:   type_bytes_r   <= cfg_wdata[TYPE_W-1:0];
        CFG_ALIGNMENT:    alignment_r    <= cfg_wdata[ALIGN_W-1:0];
        CFG_ALIGN_OFFSET: align_offset_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and pool state
  state_t              state_r, state_nxt;
  action_t             action_r, action_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                inside_r, inside_nxt;
  status_t             status_r, status_nxt;
  logic [ADDR_W-1:0]   slot_addr_r, slot_addr_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       total_r, total_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [BYTES_W-1:0]  usage_r, usage_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic [TYPE_W-1:0]   type_r, type_nxt;
  logic [IW+STRIDE_W-1:0] prod_r, prod_nxt;
  logic [AW-1:0]       fill_r, fill_nxt;

  logic accept;
  assign accept = start && !busy;

  // Region check against the live registers, compared without wrap
  logic [ADDR_W:0] region_hi;
  logic            inside_now;
  assign region_hi  = {1'b0, pool_start_r} + (ADDR_W + 1)'(pool_bytes_r);
  assign inside_now = (in_address > pool_start_r) && ({1'b0, in_address} < region_hi);

  // Rebuild layout: alignment rounded down to a power of two, start moved up
  logic [ALIGN_W-1:0]  al_smear;
  logic [ALIGN_W-1:0]  al_mask;
  logic [ALIGN_W-1:0]  al_pow;
  logic [ALIGN_W-1:0]  al_sum;
  logic [ALIGN_W-1:0]  al_rem;
  logic [ALIGN_W-1:0]  adj;
  logic [STRIDE_W-1:0] stride_calc;
  logic                reb_fits;
  logic [BYTES_W-1:0]  reb_span;

  always_comb begin
    al_smear = alignment_r;
    al_smear = al_smear | (al_smear >> 1);
    al_smear = al_smear | (al_smear >> 2);
    al_smear = al_smear | (al_smear >> 4);
    al_smear = al_smear | (al_smear >> 8);
  end

  assign al_mask     = al_smear >> 1;
  assign al_pow      = al_mask + 1'b1;
  assign al_sum      = pool_start_r[ALIGN_W-1:0] + ALIGN_W'(align_offset_r);
  assign al_rem      = al_sum & al_mask;
  assign adj         = (al_rem != '0) ? (al_pow - al_rem) : '0;
  assign stride_calc = STRIDE_W'(type_bytes_r) + STRIDE_W'(align_offset_r);
  assign reb_fits    = (stride_calc != '0) && (BYTES_W'(adj) <= pool_bytes_r);
  assign reb_span    = pool_bytes_r - BYTES_W'(adj);

  // Release precheck
  logic              rel_pre_ok;
  logic [ADDR_W-1:0] rel_delta;
  assign rel_pre_ok = (total_r != '0) && (stride_r != '0) && (addr_r >= base_r);
  assign rel_delta  = addr_r - base_r;

  // Shared divider
  logic                div_start;
  logic [ADDR_W-1:0]   div_dividend;
  logic [STRIDE_W-1:0] div_divisor;
  div_res_t            div_res;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = rel_delta;
    div_divisor  = stride_r;
    if (state_r == S_REB_SETUP) begin
      div_start    = reb_fits;
      div_dividend = ADDR_W'(reb_span);
      div_divisor  = stride_calc;
    end else if (state_r == S_REL_CHK) begin
      div_start = rel_pre_ok;
    end
  end

  fsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  logic [IW-1:0] div_count;
  logic          rel_ok;
  assign div_count = (div_res.quot > ADDR_W'(SLOTS)) ? NULL_IDX : IW'(div_res.quot);
  assign rel_ok    = (div_res.rem == '0) && (div_res.quot < ADDR_W'(total_r));

  logic [IW-1:0] fill_inc;
  logic          head_valid;
  assign fill_inc   = IW'(fill_r) + 1'b1;
  assign head_valid = (head_r != NULL_IDX) && (head_r < total_r);

  // Link RAM
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [IW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_r;
    mem_wdata = (fill_inc < total_r) ? fill_inc : NULL_IDX;
    mem_re    = (state_r == S_ALLOC_RD);
    if (state_r == S_REB_FILL) begin
      mem_we = 1'b1;
    end else if (state_r == S_REL_DIV && div_res.done && rel_ok) begin
      mem_we    = 1'b1;
      mem_waddr = div_res.quot[AW-1:0];
      mem_wdata = head_r;
    end
  end

  fsp_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_action))
            ACT_REBUILD: state_nxt = S_REB_SETUP;
            ACT_ALLOC:   state_nxt = head_valid ? S_ALLOC_RD : S_FINISH;
            ACT_RELEASE: state_nxt = S_REL_CHK;
            ACT_NOP:     state_nxt = S_FINISH;
          endcase
        end
      end
      S_REB_SETUP: state_nxt = reb_fits ? S_REB_DIV : S_FINISH;
      S_REB_DIV: begin
        if (div_res.done) begin
          state_nxt = (div_count != '0) ? S_REB_FILL : S_FINISH;
        end
      end
      S_REB_FILL: begin
        if (fill_inc >= total_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_ALLOC_RD: state_nxt = S_ALLOC_WB;
      S_ALLOC_WB: state_nxt = S_FINISH;
      S_REL_CHK:  state_nxt = rel_pre_ok ? S_REL_DIV : S_FINISH;
      S_REL_DIV: begin
        if (div_res.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    action_nxt    = action_r;
    addr_nxt      = addr_r;
    inside_nxt    = inside_r;
    status_nxt    = status_r;
    slot_addr_nxt = slot_addr_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    base_nxt      = base_r;
    usage_nxt     = usage_r;
    stride_nxt    = stride_r;
    type_nxt      = type_r;
    prod_nxt      = prod_r;
    fill_nxt      = fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          action_nxt    = action_t'(in_action);
          addr_nxt      = in_address;
          inside_nxt    = inside_now;
          slot_addr_nxt = '0;
          status_nxt    = ST_OK;
          if (action_t'(in_action) == ACT_ALLOC && !head_valid) begin
            status_nxt = ST_EMPTY;
          end
        end
      end
      S_REB_SETUP: begin
        base_nxt   = pool_start_r + ADDR_W'(adj);
        usage_nxt  = BYTES_W'(adj);
        stride_nxt = stride_calc;
        type_nxt   = type_bytes_r;
        head_nxt   = NULL_IDX;
        total_nxt  = '0;
        fill_nxt   = '0;
      end
      S_REB_DIV: begin
        if (div_res.done) begin
          total_nxt = div_count;
        end
      end
      S_REB_FILL: begin
        fill_nxt = fill_inc[AW-1:0];
        if (fill_inc >= total_r) begin
          head_nxt = '0;
        end
      end
      S_ALLOC_RD: begin
        prod_nxt = (IW+STRIDE_W)'(head_r) * (IW+STRIDE_W)'(stride_r);
      end
      S_ALLOC_WB: begin
        // Pop: the link read of the old head becomes the new head
        head_nxt      = mem_rdata;
        slot_addr_nxt = base_r + ADDR_W'(prod_r);
        usage_nxt     = usage_r + BYTES_W'(type_r);
      end
      S_REL_CHK: begin
        if (!rel_pre_ok) begin
          status_nxt = ST_BAD_ADDR;
        end
      end
      S_REL_DIV: begin
        if (div_res.done) begin
          if (rel_ok) begin
            head_nxt  = div_res.quot[IW-1:0];
            usage_nxt = usage_r - BYTES_W'(type_r);
          end else begin
            status_nxt = ST_BAD_ADDR;
          end
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= NULL_IDX;
      total_r  <= '0;
      base_r   <= '0;
      usage_r  <= '0;
      stride_r <= '0;
      type_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
      base_r   <= base_nxt;
      usage_r  <= usage_nxt;
      stride_r <= stride_nxt;
      type_r   <= type_nxt;
    end
    action_r    <= action_nxt;
    addr_r      <= addr_nxt;
    inside_r    <= inside_nxt;
    status_r    <= status_nxt;
    slot_addr_r <= slot_addr_nxt;
    prod_r      <= prod_nxt;
    fill_r      <= fill_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_FINISH);
  assign out_status       = status_r;
  assign out_slot_address = slot_addr_r;
  assign out_in_pool      = inside_r;
  assign out_used_bytes   = usage_r;

  `FSP_ASSERT(a_single_strobe, clk, rst_n, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `FSP_ASSERT(a_head_in_range, clk, rst_n, (head_r != NULL_IDX) |-> (head_r < total_r), "free head beyond slot count")
  `FSP_ASSERT(a_empty_no_addr, clk, rst_n, out_valid && (out_status == ST_EMPTY) |-> (out_slot_address == '0), "empty allocate returned an address")
  `FSP_ASSERT(a_alloc_needs_head, clk, rst_n, (state_r == S_ALLOC_RD) |-> head_valid, "link read without a free slot")

endmodule

`default_nettype wire

// ----- tb/tb_fixed_slot_pool_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_slot_pool_allocator_top
// Self-checking bench for the fixed-slot pool allocator. A queue-fed driver
// issues rebuild, allocate, release and no-op commands; a scoreboard computes
// every reply from its own copy of the registers and the free list, and the
// monitor compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fixed_slot_pool_allocator_top;
  import fsp_pkg::*;

  localparam int SLOT_COUNT = 1024;
  localparam logic [10:0] NULL_SLOT = 11'(SLOT_COUNT);

  typedef struct packed {
    logic [ADDR_W-1:0]  region_start;
    logic [BYTES_W-1:0] region_bytes;
    logic [TYPE_W-1:0]  obj_bytes;
    logic [ALIGN_W-1:0] align;
    logic [OFS_W-1:0]   hdr_bytes;
  } pool_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic [TYPE_W-1:0]   obj;
    logic [10:0]         count;
    logic [BYTES_W-1:0]  adj;
  } layout_t;

  typedef struct packed {
    action_t           act;
    logic [ADDR_W-1:0] addr;
  } pool_op_t;

  typedef struct packed {
    action_t            act;
    status_t            status;
    logic [ADDR_W-1:0]  slot;
    logic               in_pool;
    logic [BYTES_W-1:0] used;
  } pool_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic [1:0]            in_action = ACT_NOP;
  logic [ADDR_W-1:0]     in_address = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_POOL_START;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  wire                   busy;
  wire                   out_valid;
  wire [1:0]             out_status;
  wire [ADDR_W-1:0]      out_slot_address;
  wire                   out_in_pool;
  wire [BYTES_W-1:0]     out_used_bytes;

  fixed_slot_pool_allocator_top #(.SLOTS(SLOT_COUNT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_address(in_address),
    .out_valid(out_valid), .out_status(out_status),
    .out_slot_address(out_slot_address), .out_in_pool(out_in_pool),
    .out_used_bytes(out_used_bytes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scoreboard copy of the allocator
  pool_cfg_t          regs;
  logic [10:0]        link_mem [0:SLOT_COUNT-1];
  logic [10:0]        free_head = NULL_SLOT;
  logic [10:0]        slot_total = '0;
  logic [ADDR_W-1:0]  pool_base = '0;
  logic [STRIDE_W-1:0] pool_stride = '0;
  logic [TYPE_W-1:0]  pool_obj = '0;
  logic [BYTES_W-1:0] byte_usage = '0;

  pool_op_t    pool_ops_q[$];
  pool_reply_t predicted_replies[$];
  logic [ADDR_W-1:0] handed_out[$];
  layout_t     gen_layout;
  int          idle_pct = 0;
  int          err_count = 0;
  int          n_alloc_ok = 0, n_empty = 0, n_rel_ok = 0, n_bad = 0, n_rebuild = 0;

  initial begin
    regs = '{region_start: '0, region_bytes: '0, obj_bytes: 13'd16, align: 13'd8,
             hdr_bytes: '0};
    for (int i = 0; i < SLOT_COUNT; i++) link_mem[i] = '0;
    gen_layout = '0;
  end

  function automatic layout_t pool_layout(input pool_cfg_t c);
    layout_t     l;
    logic [31:0] a, r, adj, n;
    a = 32'd1;
    for (int b = 0; b < ALIGN_W; b++) if (c.align[b]) a = 32'd1 << b;
    r = (c.region_start + 32'(c.hdr_bytes)) & (a - 32'd1);
    adj = (r != 0) ? a - r : 32'd0;
    l.stride = 14'(c.obj_bytes) + 14'(c.hdr_bytes);
    n = 32'd0;
    if (l.stride != 0 && adj <= 32'(c.region_bytes))
      n = (32'(c.region_bytes) - adj) / 32'(l.stride);
    if (n > SLOT_COUNT) n = SLOT_COUNT;
    l.base = c.region_start + adj;
    l.obj = c.obj_bytes;
    l.count = 11'(n);
    l.adj = adj[BYTES_W-1:0];
    return l;
  endfunction

  task automatic predict_pool_op(input logic [1:0] act, input logic [ADDR_W-1:0] addr);
    pool_reply_t r;
    layout_t     l;
    logic [31:0] d, idx;
    logic [32:0] hi;
    logic        ok;
    r.act = action_t'(act);
    r.status = ST_OK;
    r.slot = '0;
    hi = {1'b0, regs.region_start} + 33'(regs.region_bytes);
    r.in_pool = (addr > regs.region_start) && ({1'b0, addr} < hi);
    case (act)
      ACT_REBUILD: begin
        l = pool_layout(regs);
        pool_base = l.base;
        pool_stride = l.stride;
        pool_obj = l.obj;
        slot_total = l.count;
        byte_usage = l.adj;
        for (int i = 0; i < l.count; i++)
          link_mem[i] = (i + 1 < l.count) ? 11'(i + 1) : NULL_SLOT;
        free_head = (l.count != 0) ? 11'd0 : NULL_SLOT;
      end
      ACT_ALLOC: begin
        if (free_head >= slot_total || free_head >= NULL_SLOT) begin
          r.status = ST_EMPTY;
        end else begin
          r.slot = pool_base + 32'(free_head) * 32'(pool_stride);
          free_head = link_mem[free_head];
          byte_usage = byte_usage + 24'(pool_obj);
        end
      end
      ACT_RELEASE: begin
        ok = 1'b0;
        idx = '0;
        if (slot_total != 0 && pool_stride != 0 && addr >= pool_base) begin
          d = addr - pool_base;
          if (d % 32'(pool_stride) == 0) begin
            idx = d / 32'(pool_stride);
            ok = idx < 32'(slot_total);
          end
        end
        if (!ok) begin
          r.status = ST_BAD_ADDR;
        end else begin
          link_mem[idx] = free_head;
          free_head = idx[10:0];
          byte_usage = byte_usage - 24'(pool_obj);
        end
      end
      default: ;
    endcase
    r.used = byte_usage;
    predicted_replies.push_back(r);
  endtask

  // Driver: predict on each accepted transfer, then present the next command
  always @(posedge clk) begin : drive
    pool_op_t op;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_pool_op(in_action, in_address);
      if (!start || !busy) begin
        if (pool_ops_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          op = pool_ops_q.pop_front();
          start <= 1'b1;
          in_action <= op.act;
          in_address <= op.addr;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: one reply per strobe, oldest prediction first
  always @(posedge clk) begin : watch
    pool_reply_t r;
    if (rst_n && out_valid) begin
      if (predicted_replies.size() == 0) begin
        $error("reply with no command outstanding: status %0d slot %h", out_status,
               out_slot_address);
        err_count++;
      end else begin
        r = predicted_replies.pop_front();
        if (out_status !== r.status) begin
          $error("status: expected %0d, got %0d", r.status, out_status);
          err_count++;
        end
        if (out_slot_address !== r.slot) begin
          $error("slot_address: expected %h, got %h", r.slot, out_slot_address);
          err_count++;
        end
        if (out_in_pool !== r.in_pool) begin
          $error("in_pool: expected %0d, got %0d", r.in_pool, out_in_pool);
          err_count++;
        end
        if (out_used_bytes !== r.used) begin
          $error("used_bytes: expected %h, got %h", r.used, out_used_bytes);
          err_count++;
        end
        case (r.act)
          ACT_REBUILD: n_rebuild++;
          ACT_ALLOC: begin
            if (r.status == ST_OK) begin
              n_alloc_ok++;
              handed_out.push_back(r.slot);
            end else begin
              n_empty++;
            end
          end
          ACT_RELEASE: begin
            if (r.status == ST_OK) n_rel_ok++;
            else n_bad++;
          end
          default: ;
        endcase
      end
    end
  end

  task automatic push_op(input action_t act, input logic [ADDR_W-1:0] addr);
    pool_op_t op;
    while (pool_ops_q.size() >= 2) @(posedge clk);
    op.act = act;
    op.addr = addr;
    pool_ops_q.push_back(op);
  endtask

  task automatic push_rebuild();
    gen_layout = pool_layout(regs);
    handed_out.delete();
    push_op(ACT_REBUILD, $urandom);
  endtask

  // Wait until every command is replied to and the block is idle
  task automatic drain_pool();
    while (pool_ops_q.size() != 0 || start || predicted_replies.size() != 0)
      @(posedge clk);
    while (busy) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_POOL_START:   regs.region_start = data;
      CFG_POOL_BYTES:   regs.region_bytes = data[BYTES_W-1:0];
      CFG_TYPE_BYTES:   regs.obj_bytes = data[TYPE_W-1:0];
      CFG_ALIGNMENT:    regs.align = data[ALIGN_W-1:0];
      CFG_ALIGN_OFFSET: regs.hdr_bytes = data[OFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input pool_cfg_t c);
    cfg_write(CFG_POOL_START, c.region_start);
    cfg_write(CFG_POOL_BYTES, 32'(c.region_bytes));
    cfg_write(CFG_TYPE_BYTES, 32'(c.obj_bytes));
    cfg_write(CFG_ALIGNMENT, 32'(c.align));
    cfg_write(CFG_ALIGN_OFFSET, 32'(c.hdr_bytes));
    cfg_done();
  endtask

  function automatic pool_cfg_t random_cfg(input int family);
    pool_cfg_t c;
    c.region_start = $urandom;
    case (family)
      0: begin  // a handful of slots, so the list runs dry
        c.region_bytes = 24'($urandom_range(300));
        c.obj_bytes = 13'($urandom_range(40, 9));
        c.align = 13'($urandom_range(64));
        c.hdr_bytes = 12'($urandom_range(12));
      end
      1: begin
        c.region_bytes = 24'($urandom_range(60000));
        c.obj_bytes = 13'($urandom_range(200, 9));
        c.align = 13'($urandom_range(512, 1));
        c.hdr_bytes = 12'($urandom_range(64));
      end
      2: begin  // region can hold more slots than the link memory
        c.region_bytes = 24'($urandom_range(24'hFFFFFF, 24'h400000));
        c.obj_bytes = 13'($urandom_range(4096, 9));
        c.align = 13'(1 << $urandom_range(12));
        c.hdr_bytes = 12'($urandom_range(4095));
      end
      default: begin
        c.region_bytes = 24'($urandom);
        c.obj_bytes = 13'($urandom);
        c.align = 13'($urandom);
        c.hdr_bytes = 12'($urandom);
      end
    endcase
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] broken_release_addr();
    logic [ADDR_W-1:0] a;
    case ($urandom_range(3))
      0: a = gen_layout.base + 32'($urandom_range(gen_layout.count)) * gen_layout.stride
             + ((gen_layout.stride > 1) ? 32'($urandom_range(gen_layout.stride - 1, 1))
                                        : 32'd1);
      1: a = gen_layout.base - 32'($urandom_range(64, 1));
      2: a = $urandom;
      default: a = gen_layout.base + 32'(gen_layout.count) * 32'(gen_layout.stride);
    endcase
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] edge_probe_addr();
    logic [ADDR_W-1:0] a;
    case ($urandom_range(4))
      0: a = regs.region_start;
      1: a = regs.region_start + 32'd1;
      2: a = regs.region_start + 32'(regs.region_bytes) - 32'd1;
      3: a = regs.region_start + 32'(regs.region_bytes);
      default: a = regs.region_start - 32'd1;
    endcase
    return a;
  endfunction

  task automatic run_random_phase(input int family, input int idle, input int n_ops);
    logic [ADDR_W-1:0] a;
    int                pick, idx;
    drain_pool();
    idle_pct = idle;
    program_regs(random_cfg(family));
    push_rebuild();
    for (int k = 0; k < n_ops; k++) begin
      if (k == n_ops / 2) begin
        // hold the sender until every reply is in; maybe move a live register
        drain_pool();
        if ($urandom_range(1) == 1) begin
          cfg_write(cfg_reg_t'(3'($urandom_range(4))), $urandom);
          cfg_done();
        end
      end
      pick = $urandom_range(99);
      if (pick < 42) begin
        push_op(ACT_ALLOC, $urandom);
      end else if (pick < 72 && handed_out.size() != 0) begin
        idx = $urandom_range(handed_out.size() - 1);
        a = handed_out[idx];
        handed_out.delete(idx);
        push_op(ACT_RELEASE, a);
      end else if (pick < 80) begin
        push_op(ACT_RELEASE, gen_layout.base
                + 32'($urandom_range(gen_layout.count)) * 32'(gen_layout.stride));
      end else if (pick < 89) begin
        push_op(ACT_RELEASE, broken_release_addr());
      end else if (pick < 94) begin
        push_op(ACT_NOP, $urandom);
      end else if (pick < 96) begin
        push_rebuild();
      end else begin
        push_op(action_t'(2'($urandom_range(3))), edge_probe_addr());
      end
    end
  endtask

  initial begin : stimulus
    int fam[8];
    int idl[8];
    fam = '{0, 0, 1, 3, 2, 0, 3, 1};
    idl = '{0, 64, 0, 34, 0, 64, 34, 64};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: empty list, nothing releasable, rebuild of an empty region
    push_op(ACT_ALLOC, 32'h0);
    push_op(ACT_RELEASE, 32'h0);
    push_op(ACT_NOP, 32'hFFFF_FFFF);
    push_rebuild();

    // Non-power-of-two alignment, slots wrapping past zero, counter wrap
    drain_pool();
    program_regs('{region_start: 32'hFFFF_FFF3, region_bytes: 24'd100, obj_bytes: 13'd20,
                   align: 13'd13, hdr_bytes: 12'd4});
    push_rebuild();
    push_op(ACT_RELEASE, gen_layout.base);
    push_rebuild();
    repeat (5) push_op(ACT_ALLOC, $urandom);
    push_op(ACT_RELEASE, gen_layout.base + 32'd1);
    push_op(ACT_RELEASE, gen_layout.base + 32'(gen_layout.stride));
    push_op(ACT_RELEASE, gen_layout.base + 32'd4 * 32'(gen_layout.stride));

    // All-zero registers: zero stride, zero slots
    drain_pool();
    program_regs('0);
    push_rebuild();
    push_op(ACT_ALLOC, 32'h0);

    // Alignment adjustment past the region end; region edge probes
    drain_pool();
    program_regs('{region_start: 32'd1, region_bytes: 24'd100, obj_bytes: 13'd9,
                   align: 13'd4096, hdr_bytes: 12'd0});
    push_rebuild();
    push_op(ACT_NOP, 32'd1);
    push_op(ACT_NOP, 32'd2);
    push_op(ACT_NOP, 32'd100);
    push_op(ACT_NOP, 32'd101);

    // Maximum registers, slot count capped; later type write must not matter
    drain_pool();
    program_regs('{region_start: 32'hFFFF_FFFF, region_bytes: 24'hFFFFFF,
                   obj_bytes: 13'h1FFF, align: 13'h1FFF, hdr_bytes: 12'hFFF});
    push_rebuild();
    push_op(ACT_ALLOC, $urandom);
    push_op(ACT_RELEASE, gen_layout.base + 32'(SLOT_COUNT) * 32'(gen_layout.stride));
    drain_pool();
    cfg_write(CFG_TYPE_BYTES, 32'd9);
    cfg_done();
    push_op(ACT_ALLOC, $urandom);
    push_op(ACT_RELEASE, gen_layout.base);

    for (int p = 0; p < 8; p++) run_random_phase(fam[p], idl[p], 240);

    drain_pool();
    repeat (40) @(posedge clk);
    $display("covered %0d rebuilds, %0d grants, %0d empty allocates,", n_rebuild,
             n_alloc_ok, n_empty);
    $display("  %0d accepted and %0d refused releases, %0d mismatches", n_rel_ok, n_bad,
             err_count);
    if (err_count == 0) begin
      $display("PASS fixed_slot_pool_allocator_top");
    end else begin
      $display("FAIL fixed_slot_pool_allocator_top");
    end
    $finish;
  end

  initial begin : watchdog
    #80_000_000;
    $display("FAIL fixed_slot_pool_allocator_top");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/fsp_pkg.sv
sv/fsp_ram.sv
sv/fsp_div.sv
sv/fixed_slot_pool_allocator_top.sv
tb/tb_fixed_slot_pool_allocator_top.sv
